[hdl/coab_pkg.sv]
// ============================================================================
// Cursor overlay alpha blend: shared package
// Types and constants used by the cursor overlay modules.
// ============================================================================
package coab_pkg;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_CURSOR_LEFT   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CURSOR_TOP    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CURSOR_WIDTH  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CURSOR_HEIGHT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_LAYOUT  = 3'd4;

    // Pixel layout codes
    localparam logic [1:0] LAYOUT_RED_HIGH = 2'd0;
    localparam logic [1:0] LAYOUT_RED_LOW  = 2'd1;
    localparam logic [1:0] LAYOUT_PASS     = 2'd2;

    // Input kinds carried on tuser
    localparam logic ACTION_LOAD  = 1'b0;
    localparam logic ACTION_BLEND = 1'b1;

    // Stream widths
    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 24;

    // Control for a blend request leaving the coordinate stage
    typedef struct packed {
        logic valid;     // a blend request is present
        logic hit;       // cursor covers the pixel and blending applies
        logic red_low;   // red sits in byte 0, blue in byte 2
    } coab_ctl_t;

endpackage

[hdl/coab_hit.sv]
// ============================================================================
// Cursor overlay: coordinate test
// Decides whether the cursor rectangle covers a pixel and forms the store
// address of the cursor word that lies under it.
// ============================================================================
module coab_hit #(
    parameter int CURSOR_MAX_W = 64,
    parameter int CURSOR_MAX_H = 64
) (
    input  logic                                        blend,
    input  logic [13:0]                                 pixel_x,
    input  logic [13:0]                                 pixel_y,
    input  logic [15:0]                                 origin_col,
    input  logic [15:0]                                 origin_row,
    input  logic [6:0]                                  cursor_width,
    input  logic [6:0]                                  cursor_height,
    input  logic [1:0]                                  pixel_layout,
    output coab_pkg::coab_ctl_t                         ctl,
    output logic [$clog2(CURSOR_MAX_W*CURSOR_MAX_H)-1:0] addr
);

    localparam int AW = $clog2(CURSOR_MAX_W * CURSOR_MAX_H);
    localparam int CW = $clog2(CURSOR_MAX_W);
    localparam int RW = $clog2(CURSOR_MAX_H);
    localparam logic [9:0] MAX_W_L = 10'(CURSOR_MAX_W);
    localparam logic [9:0] MAX_H_L = 10'(CURSOR_MAX_H);

    logic signed [17:0] dx;
    logic signed [17:0] dy;
    logic [9:0]         w_eff;
    logic [9:0]         h_eff;
    logic               inside_x;
    logic               inside_y;
    logic               layout_ok;

    // Offsets of the pixel from the cursor origin.
    assign dx = $signed({4'd0, pixel_x}) - 18'(signed'(origin_col));
    assign dy = $signed({4'd0, pixel_y}) - 18'(signed'(origin_row));

    // The rectangle in use is clipped to the size of the store.
    assign w_eff = ({3'd0, cursor_width} > MAX_W_L) ? MAX_W_L : {3'd0, cursor_width};
    assign h_eff = ({3'd0, cursor_height} > MAX_H_L) ? MAX_H_L : {3'd0, cursor_height};

    assign inside_x  = !dx[17] && (dx < $signed({8'd0, w_eff}));
    assign inside_y  = !dy[17] && (dy < $signed({8'd0, h_eff}));
    assign layout_ok = (pixel_layout == coab_pkg::LAYOUT_RED_HIGH) ||
                       (pixel_layout == coab_pkg::LAYOUT_RED_LOW);

    always_comb begin
        ctl.valid   = blend;
        ctl.hit     = blend && layout_ok && inside_x && inside_y;
        ctl.red_low = (pixel_layout == coab_pkg::LAYOUT_RED_LOW);
    end

    // Row-major address; only meaningful when the pixel is covered.
    assign addr = AW'(dy[RW-1:0]) * AW'(CURSOR_MAX_W) + AW'(dx[CW-1:0]);

endmodule

[hdl/coab_store.sv]
// ============================================================================
// Cursor overlay: cursor bitmap store
// Single write port, single read port, registered read data.
// ============================================================================
module coab_store #(
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [31:0]              wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [31:0]              rd_data_reg
);

    logic [31:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds while the pipeline is stalled.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

[hdl/coab_mix.sv]
// ============================================================================
// Cursor overlay: channel blend
// Two register stages: the scaled frame channel, then the divide by 255,
// the premultiplied cursor add and the final selection.
// ============================================================================
module coab_mix (
    input  logic       aclk,
    input  logic       en,
    input  logic       hit,
    input  logic [7:0] p,
    input  logic [7:0] a,
    input  logic [7:0] c,
    output logic [7:0] q_reg
);

    logic [15:0] prod_reg;
    logic [7:0]  p_reg;
    logic [7:0]  c_reg;
    logic        full_reg;
    logic        hit_reg;
    logic [16:0] sum;
    logic [7:0]  quot;
    logic [7:0]  blend;
    logic [7:0]  q_next;

    // Stage one: frame channel times inverse alpha, plus the rounding term.
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= 16'(p) * (16'd255 - 16'(a)) + 16'd127;
            p_reg    <= p;
            c_reg    <= c;
            full_reg <= (a == 8'd255);
            hit_reg  <= hit;
        end
    end

    // Exact division by 255 for values below 65280.
    assign sum  = {1'b0, prod_reg} + {9'd0, prod_reg[15:8]} + 17'd1;
    assign quot = sum[15:8];

    // Full alpha takes the cursor colour; otherwise add it with 8-bit wrap.
    assign blend  = full_reg ? c_reg : 8'(quot + c_reg);
    assign q_next = hit_reg ? blend : p_reg;

    // Stage two: result byte.
    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= q_next;
        end
    end

endmodule

[hdl/cursor_overlay_alpha_blend_unit.sv]
// ============================================================================
// Cursor overlay alpha blend unit
// Overlays a stored premultiplied-alpha cursor bitmap onto a pixel stream.
// ============================================================================
// Usage:
//   The slave stream carries two kinds of request, chosen by s_tuser. A load
//   request writes one cursor word into the bitmap store and produces nothing.
//   A blend request carries a frame pixel and its coordinates and produces
//   one blended pixel on the master stream, with m_tuser flagging a cursor hit.
//   Both kinds are taken at one per clock cycle unless the pipeline is stalled.
//   A blend result is registered by the synchronous read of the bitmap store,
//   then by the channel multipliers, then by the divide-by-255 and cursor add,
//   and appears on the master side. Loads write at acceptance, so a blend in
//   the very next cycle already sees the new word. The whole pipeline advances
//   together; when the receiver holds m_tready low with a result waiting,
//   s_tready falls and all stages hold. The user writes registers through the
//   cfg port while no blend is in flight; the unit does not enforce this.
//   Reset empties the pipeline and sets layout to pass-through with an empty
//   cursor rectangle; the bitmap contents are undefined until loaded.
// ============================================================================
module cursor_overlay_alpha_blend_unit #(
    parameter int CURSOR_MAX_W = 64,
    parameter int CURSOR_MAX_H = 64
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    // Configuration write port
    input  logic                                  cfg_wr_en,
    input  logic [coab_pkg::CFG_INDEX_W-1:0]      cfg_wr_index,
    input  logic [coab_pkg::CFG_DATA_W-1:0]       cfg_wr_data,

    // Request stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // cursor_index[11:0], cursor_argb[43:12], pixel_x[57:44], pixel_y[71:58],
    // in_byte_0[79:72], in_byte_1[87:80], in_byte_2[95:88]
    input  logic [coab_pkg::S_TDATA_W-1:0]        s_tdata,
    // action[0]
    input  logic                                  s_tuser,

    // Result stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // out_byte_0[7:0], out_byte_1[15:8], out_byte_2[23:16]
    output logic [coab_pkg::M_TDATA_W-1:0]        m_tdata,
    // cursor_hit[0]
    output logic                                  m_tuser
);

    localparam int DEPTH = CURSOR_MAX_W * CURSOR_MAX_H;
    localparam int AW    = $clog2(DEPTH);

    // Configuration registers
    logic [15:0] left_reg;
    logic [15:0] top_reg;
    logic [6:0]  width_reg;
    logic [6:0]  height_reg;
    logic [1:0]  layout_reg;

    // Input fields
    logic [11:0] cursor_index;
    logic [31:0] cursor_argb;
    logic [13:0] pixel_x;
    logic [13:0] pixel_y;
    logic [7:0]  in_byte_0;
    logic [7:0]  in_byte_1;
    logic [7:0]  in_byte_2;

    logic                  advance;
    logic                  accept;
    logic                  load_wr;
    logic [31:0]           index_ext;
    coab_pkg::coab_ctl_t   ctl;
    logic [AW-1:0]         rd_addr;
    logic [31:0]           word;

    // Pipeline state
    logic                  valid_a_reg;
    logic                  hit_a_reg;
    logic                  red_low_a_reg;
    logic [7:0]            byte0_a_reg;
    logic [7:0]            byte1_a_reg;
    logic [7:0]            byte2_a_reg;
    logic                  valid_b_reg;
    logic                  hit_b_reg;
    logic                  m_tvalid_reg;
    logic                  m_hit_reg;

    logic [7:0]            c0;
    logic [7:0]            c2;
    logic [7:0]            out0;
    logic [7:0]            out1;
    logic [7:0]            out2;

    assign cursor_index = s_tdata[11:0];
    assign cursor_argb  = s_tdata[43:12];
    assign pixel_x      = s_tdata[57:44];
    assign pixel_y      = s_tdata[71:58];
    assign in_byte_0    = s_tdata[79:72];
    assign in_byte_1    = s_tdata[87:80];
    assign in_byte_2    = s_tdata[95:88];

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg   <= '0;
            top_reg    <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            layout_reg <= coab_pkg::LAYOUT_PASS;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                coab_pkg::REG_CURSOR_LEFT:   left_reg   <= cfg_wr_data;
                coab_pkg::REG_CURSOR_TOP:    top_reg    <= cfg_wr_data;
                coab_pkg::REG_CURSOR_WIDTH:  width_reg  <= cfg_wr_data[6:0];
                coab_pkg::REG_CURSOR_HEIGHT: height_reg <= cfg_wr_data[6:0];
                coab_pkg::REG_PIXEL_LAYOUT:  layout_reg <= cfg_wr_data[1:0];
                default: ;
            endcase
        end
    end

    // The whole pipeline moves whenever the output register can take a result.
    assign advance  = !m_tvalid_reg || m_tready;
    assign s_tready = advance;
    assign accept   = s_tvalid && advance;

    // Loads beyond the store are dropped.
    assign index_ext = 32'(cursor_index);
    assign load_wr   = accept && (s_tuser == coab_pkg::ACTION_LOAD) &&
                       (index_ext < 32'(DEPTH));

    // Coordinate test and store address.
    coab_hit #(
        .CURSOR_MAX_W (CURSOR_MAX_W),
        .CURSOR_MAX_H (CURSOR_MAX_H)
    ) u_hit (
        .blend         (s_tuser == coab_pkg::ACTION_BLEND),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .origin_col    (left_reg),
        .origin_row    (top_reg),
        .cursor_width  (width_reg),
        .cursor_height (height_reg),
        .pixel_layout  (layout_reg),
        .ctl           (ctl),
        .addr          (rd_addr)
    );

    // Bitmap store; a read and a write never belong to the same request.
    coab_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .aclk        (aclk),
        .wr_en       (load_wr),
        .wr_addr     (index_ext[AW-1:0]),
        .wr_data     (cursor_argb),
        .rd_en       (advance),
        .rd_addr     (rd_addr),
        .rd_data_reg (word)
    );

    // Stage A control, alongside the store read.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
        end else if (advance) begin
            valid_a_reg <= s_tvalid && ctl.valid;
        end
    end

    // Stage A payload.
    always_ff @(posedge aclk) begin
        if (advance) begin
            hit_a_reg     <= ctl.hit;
            red_low_a_reg <= ctl.red_low;
            byte0_a_reg   <= in_byte_0;
            byte1_a_reg   <= in_byte_1;
            byte2_a_reg   <= in_byte_2;
        end
    end

    // Cursor channel for each byte position.
    assign c0 = red_low_a_reg ? word[23:16] : word[7:0];
    assign c2 = red_low_a_reg ? word[7:0]   : word[23:16];

    coab_mix u_mix0 (
        .aclk  (aclk),
        .en    (advance),
        .hit   (hit_a_reg),
        .p     (byte0_a_reg),
        .a     (word[31:24]),
        .c     (c0),
        .q_reg (out0)
    );

    coab_mix u_mix1 (
        .aclk  (aclk),
        .en    (advance),
        .hit   (hit_a_reg),
        .p     (byte1_a_reg),
        .a     (word[31:24]),
        .c     (word[15:8]),
        .q_reg (out1)
    );

    coab_mix u_mix2 (
        .aclk  (aclk),
        .en    (advance),
        .hit   (hit_a_reg),
        .p     (byte2_a_reg),
        .a     (word[31:24]),
        .c     (c2),
        .q_reg (out2)
    );

    // Stage B and output stage control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_b_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            valid_b_reg  <= valid_a_reg;
            m_tvalid_reg <= valid_b_reg;
        end
    end

    // Hit flag follows its pixel down the pipeline.
    always_ff @(posedge aclk) begin
        if (advance) begin
            hit_b_reg <= hit_a_reg;
            m_hit_reg <= hit_b_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out2, out1, out0};
    assign m_tuser  = m_hit_reg;

endmodule

[verif/tb_cursor_overlay_alpha_blend_unit.sv]
`timescale 1ns / 100ps
// ============================================================================
// Cursor overlay alpha blend unit: self-checking testbench
// Drives load and blend requests into the unit. A predictor keeps its own
// copy of the cursor bitmap and the window registers, and works out each
// blended pixel. Directed tests come first, then random traffic under
// several patterns of source gaps and sink back-pressure.
// ============================================================================
module tb_cursor_overlay_alpha_blend_unit;

    localparam int CURSOR_MAX_W = 64;
    localparam int CURSOR_MAX_H = 64;
    localparam int BITMAP_WORDS = CURSOR_MAX_W * CURSOR_MAX_H;
    localparam int PIPE_SETTLE  = 6;
    localparam int CYCLE_LIMIT  = 400000;

    // Codes the package leaves unnamed
    localparam logic [1:0] LAYOUT_PASS_ALT = 2'd3;
    localparam logic [coab_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO =
        coab_pkg::REG_PIXEL_LAYOUT + 3'd1;

    typedef struct {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic       hit;
    } blend_result_t;

    // DUT connections
    logic                             aclk;
    logic                             aresetn;
    logic                             cfg_wr_en;
    logic [coab_pkg::CFG_INDEX_W-1:0] cfg_wr_index;
    logic [coab_pkg::CFG_DATA_W-1:0]  cfg_wr_data;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [coab_pkg::S_TDATA_W-1:0]   s_tdata;
    logic                             s_tuser;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [coab_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                             m_tuser;

    // Predictor state: window registers and cursor bitmap
    logic signed [15:0] win_left;
    logic signed [15:0] win_top;
    logic [6:0]         win_width;
    logic [6:0]         win_height;
    logic [1:0]         win_layout;
    logic [31:0]        bitmap [0:BITMAP_WORDS-1];
    bit                 bitmap_loaded [0:BITMAP_WORDS-1];

    blend_result_t blended_due [$];

    int src_idle_pct;
    int sink_stall_pct;
    int error_count;
    int cycle_count;
    int loads_sent;
    int blends_sent;
    int results_checked;
    int hits_seen;
    int cfg_writes;

    cursor_overlay_alpha_blend_unit uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser)
    );

    // Clock generation, 4 ns period
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Random back-pressure from the result sink
    always @(negedge aclk) begin
        m_tready = ($urandom_range(99) >= sink_stall_pct);
    end

    // Run-time guard
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t ns: timed out with %0d results outstanding",
                     $time, blended_due.size());
            $display("tb_cursor_overlay_alpha_blend_unit: errors");
            $finish;
        end
    end

    // Returns whether the cursor covers the pixel, and the bitmap address it maps to
    function automatic bit window_lookup(input logic [13:0] px, input logic [13:0] py,
                                         output int addr);
        int dx, dy, w, h;
        dx = int'(px) - int'(win_left);
        dy = int'(py) - int'(win_top);
        w = (win_width > CURSOR_MAX_W) ? CURSOR_MAX_W : int'(win_width);
        h = (win_height > CURSOR_MAX_H) ? CURSOR_MAX_H : int'(win_height);
        addr = dy * CURSOR_MAX_W + dx;
        return (win_layout == coab_pkg::LAYOUT_RED_HIGH ||
                win_layout == coab_pkg::LAYOUT_RED_LOW) &&
               dx >= 0 && dx < w && dy >= 0 && dy < h;
    endfunction

    // Premultiplied over: scale the frame channel by (255 - alpha), add the cursor
    function automatic logic [7:0] blend_channel(input logic [7:0] p, input logic [7:0] a,
                                                 input logic [7:0] c);
        int unsigned acc;
        if (a == 8'hFF)
            return c;
        acc = (int'(p) * (255 - int'(a)) + 127) / 255 + int'(c);
        return 8'(acc);
    endfunction

    // Cursor word with alpha weighted towards fully clear and fully opaque
    function automatic logic [31:0] random_cursor_word();
        logic [31:0] word;
        word = $urandom();
        case ($urandom_range(3))
            0: word[31:24] = 8'h00;
            1: word[31:24] = 8'hFF;
            default: ;
        endcase
        return word;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            error_count++;
            $display("%0t ns: %s mismatch, expected %0h actual %0h",
                     $time, name, want, got);
        end
    endtask

    // Compare each accepted result with the oldest prediction
    always @(posedge aclk) begin
        blend_result_t due;
        if (aresetn && m_tvalid && m_tready) begin
            results_checked++;
            if (m_tuser)
                hits_seen++;
            if (blended_due.size() == 0) begin
                error_count++;
                $display("%0t ns: unexpected result, expected none actual %h/%b",
                         $time, m_tdata, m_tuser);
            end else begin
                due = blended_due.pop_front();
                check_field("out_byte_0", due.byte0, m_tdata[7:0]);
                check_field("out_byte_1", due.byte1, m_tdata[15:8]);
                check_field("out_byte_2", due.byte2, m_tdata[23:16]);
                check_field("cursor_hit", due.hit, m_tuser);
            end
        end
    end

    // Present one request, wait for the handshake and update the predictor
    task automatic push_request(input logic kind, input logic [11:0] idx,
                                input logic [31:0] argb, input logic [13:0] px,
                                input logic [13:0] py, input logic [7:0] p0,
                                input logic [7:0] p1, input logic [7:0] p2);
        blend_result_t res;
        int            addr;
        logic [31:0]   word;
        logic [7:0]    c0, c2;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = {p2, p1, p0, py, px, argb, idx};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (kind == coab_pkg::ACTION_LOAD) begin
            bitmap[idx]        = argb;
            bitmap_loaded[idx] = 1'b1;
            loads_sent++;
        end else begin
            res = '{byte0: p0, byte1: p1, byte2: p2, hit: 1'b0};
            if (window_lookup(px, py, addr)) begin
                word = bitmap[addr];
                c0 = (win_layout == coab_pkg::LAYOUT_RED_HIGH) ? word[7:0] : word[23:16];
                c2 = (win_layout == coab_pkg::LAYOUT_RED_HIGH) ? word[23:16] : word[7:0];
                res.byte0 = blend_channel(p0, word[31:24], c0);
                res.byte1 = blend_channel(p1, word[31:24], word[15:8]);
                res.byte2 = blend_channel(p2, word[31:24], c2);
                res.hit   = 1'b1;
            end
            blended_due.push_back(res);
            blends_sent++;
        end
        @(negedge aclk);
    endtask

    task automatic load_word(input logic [11:0] idx, input logic [31:0] word);
        push_request(coab_pkg::ACTION_LOAD, idx, word, 14'($urandom()), 14'($urandom()),
                     8'($urandom()), 8'($urandom()), 8'($urandom()));
    endtask

    // Blend one pixel; a covered entry that was never loaded gets a word first
    task automatic blend_pixel(input logic [13:0] px, input logic [13:0] py,
                               input logic [7:0] p0, input logic [7:0] p1,
                               input logic [7:0] p2);
        int addr;
        if (window_lookup(px, py, addr) && !bitmap_loaded[addr])
            load_word(12'(addr), random_cursor_word());
        push_request(coab_pkg::ACTION_BLEND, 12'($urandom()), $urandom(), px, py,
                     p0, p1, p2);
    endtask

    // Let every expected result arrive and the pipeline empty
    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (blended_due.size() != 0)
            @(negedge aclk);
        repeat (PIPE_SETTLE) @(negedge aclk);
    endtask

    task automatic write_register(input logic [coab_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [coab_pkg::CFG_DATA_W-1:0] data);
        cfg_wr_en    = 1'b1;
        cfg_wr_index = idx;
        cfg_wr_data  = data;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        cfg_writes++;
        case (idx)
            coab_pkg::REG_CURSOR_LEFT:   win_left   = data;
            coab_pkg::REG_CURSOR_TOP:    win_top    = data;
            coab_pkg::REG_CURSOR_WIDTH:  win_width  = data[6:0];
            coab_pkg::REG_CURSOR_HEIGHT: win_height = data[6:0];
            coab_pkg::REG_PIXEL_LAYOUT:  win_layout = data[1:0];
            default: ;
        endcase
    endtask

    // Drain, then program the whole cursor window
    task automatic set_window(input logic [15:0] left, input logic [15:0] top,
                              input logic [15:0] wdata, input logic [15:0] hdata,
                              input logic [15:0] ldata);
        wait_idle();
        write_register(coab_pkg::REG_CURSOR_LEFT, left);
        write_register(coab_pkg::REG_CURSOR_TOP, top);
        write_register(coab_pkg::REG_CURSOR_WIDTH, wdata);
        write_register(coab_pkg::REG_CURSOR_HEIGHT, hdata);
        write_register(coab_pkg::REG_PIXEL_LAYOUT, ldata);
    endtask

    // After reset the layout passes pixels through untouched
    task automatic test_reset_state();
        blend_pixel(14'd0, 14'd0, 8'h5A, 8'hA5, 8'h3C);
        blend_pixel(14'h3FFF, 14'h3FFF, 8'hFF, 8'h00, 8'hFF);
    endtask

    // Opaque, clear, partial and wrapping alpha inside a small window
    task automatic test_blend_rules();
        set_window(16'd10, 16'd20, 16'd3, 16'd2, 16'(coab_pkg::LAYOUT_RED_HIGH));
        load_word(12'd0, 32'hFF112233);
        load_word(12'd1, 32'h00000000);
        load_word(12'd2, 32'h80402010);
        load_word(12'd64, 32'h7F7F7F7F);
        load_word(12'd65, 32'hFFFFFFFF);
        load_word(12'd66, 32'h01FFFFFF);
        blend_pixel(14'd10, 14'd20, 8'hFF, 8'hFF, 8'hFF);
        blend_pixel(14'd11, 14'd20, 8'h00, 8'h80, 8'hFF);
        blend_pixel(14'd12, 14'd20, 8'hFF, 8'h00, 8'h80);
        blend_pixel(14'd10, 14'd21, 8'h00, 8'hFF, 8'h00);
        blend_pixel(14'd11, 14'd21, 8'h12, 8'h34, 8'h56);
        blend_pixel(14'd12, 14'd21, 8'hFF, 8'hFF, 8'hFF);
        // Just outside the right, left and bottom edges of the window
        blend_pixel(14'd13, 14'd20, 8'h11, 8'h22, 8'h33);
        blend_pixel(14'd9, 14'd20, 8'h44, 8'h55, 8'h66);
        blend_pixel(14'd10, 14'd22, 8'h77, 8'h88, 8'h99);
    endtask

    // Red/blue swap and both pass-through layouts
    task automatic test_layout_modes();
        set_window(16'd10, 16'd20, 16'd3, 16'd2, 16'(coab_pkg::LAYOUT_RED_LOW));
        blend_pixel(14'd12, 14'd20, 8'hFF, 8'h00, 8'h80);
        set_window(16'd10, 16'd20, 16'd3, 16'd2, 16'(LAYOUT_PASS_ALT));
        blend_pixel(14'd10, 14'd20, 8'h01, 8'h02, 8'h03);
        set_window(16'd10, 16'd20, 16'd3, 16'd2, 16'(coab_pkg::LAYOUT_PASS));
        blend_pixel(14'd11, 14'd20, 8'hFE, 8'hFD, 8'hFC);
    endtask

    // Negative origin, empty and oversized cursor, frame corner, spare registers
    task automatic test_window_edges();
        set_window(16'hFFFF, 16'hFFFF, 16'd3, 16'd2, 16'(coab_pkg::LAYOUT_RED_HIGH));
        blend_pixel(14'd0, 14'd0, 8'h80, 8'h80, 8'h80);
        set_window(16'd0, 16'd0, 16'd0, 16'd2, 16'(coab_pkg::LAYOUT_RED_HIGH));
        blend_pixel(14'd0, 14'd0, 8'h80, 8'h80, 8'h80);
        // Width and height above the bitmap size saturate to it
        set_window(16'd0, 16'd0, 16'hFFC1, 16'd100, 16'(coab_pkg::LAYOUT_RED_HIGH));
        load_word(12'd4095, 32'hFF000000);
        blend_pixel(14'd63, 14'd63, 8'hFF, 8'hFF, 8'hFF);
        blend_pixel(14'd64, 14'd0, 8'h10, 8'h20, 8'h30);
        blend_pixel(14'd0, 14'd64, 8'h40, 8'h50, 8'h60);
        set_window(16'd16380, 16'd16380, 16'd4, 16'd4, 16'(coab_pkg::LAYOUT_RED_LOW));
        blend_pixel(14'h3FFF, 14'h3FFF, 8'hC3, 8'h3C, 8'h99);
        set_window(16'h8000, 16'h7FFF, 16'd64, 16'd64, 16'(coab_pkg::LAYOUT_RED_HIGH));
        write_register(REG_SPARE_LO, 16'hFFFF);
        write_register(REG_SPARE_LO + 3'd1, 16'hFFFF);
        write_register(REG_SPARE_LO + 3'd2, 16'hFFFF);
        blend_pixel(14'd0, 14'd0, 8'hAA, 8'hBB, 8'hCC);
    endtask

    function automatic logic [15:0] random_origin();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'(-int'($urandom_range(1, 70)));
            3: return 16'($urandom_range(16300, 16383));
            default: return 16'($urandom_range(0, 600));
        endcase
    endfunction

    // Register data with noise in the bits above the size field
    function automatic logic [15:0] random_size();
        logic [6:0] size;
        case ($urandom_range(7))
            0: size = 7'd0;
            1: size = 7'd64;
            2: size = 7'($urandom_range(65, 127));
            default: size = 7'($urandom_range(1, 64));
        endcase
        return {9'($urandom()), size};
    endfunction

    function automatic logic [15:0] random_layout();
        logic [1:0] lay;
        case ($urandom_range(9))
            0: lay = coab_pkg::LAYOUT_PASS;
            1: lay = LAYOUT_PASS_ALT;
            2, 3, 4, 5: lay = coab_pkg::LAYOUT_RED_HIGH;
            default: lay = coab_pkg::LAYOUT_RED_LOW;
        endcase
        return {14'($urandom()), lay};
    endfunction

    function automatic logic [13:0] near_window(input int origin, input int span);
        int pos;
        pos = origin + int'($urandom_range(0, span + 7)) - 4;
        if (pos < 0)
            pos = 0;
        if (pos > 16383)
            pos = 16383;
        return 14'(pos);
    endfunction

    // New random window, then a burst of loads and blends mostly around it
    task automatic random_segment();
        int n, sel, w, h;
        set_window(random_origin(), random_origin(), random_size(), random_size(),
                   random_layout());
        if ($urandom_range(3) == 0)
            write_register(REG_SPARE_LO + 3'($urandom_range(0, 2)), 16'($urandom()));
        w = (win_width > CURSOR_MAX_W) ? CURSOR_MAX_W : int'(win_width);
        h = (win_height > CURSOR_MAX_H) ? CURSOR_MAX_H : int'(win_height);
        n = $urandom_range(35, 65);
        repeat (n) begin
            sel = $urandom_range(99);
            if (sel < 12) begin
                load_word(12'($urandom()), random_cursor_word());
            end else if (sel < 20 && w > 0 && h > 0) begin
                load_word(12'($urandom_range(0, h - 1) * CURSOR_MAX_W +
                              $urandom_range(0, w - 1)), random_cursor_word());
            end else if (sel < 75) begin
                blend_pixel(near_window(int'(win_left), w), near_window(int'(win_top), h),
                            8'($urandom()), 8'($urandom()), 8'($urandom()));
            end else begin
                blend_pixel(14'($urandom()), 14'($urandom()),
                            8'($urandom()), 8'($urandom()), 8'($urandom()));
            end
        end
    endtask

    task automatic test_random_traffic(input int src_idle, input int sink_stall,
                                       input int segments);
        wait_idle();
        src_idle_pct   = src_idle;
        sink_stall_pct = sink_stall;
        repeat (segments) random_segment();
    endtask

    // Test sequence
    initial begin
        aclk           = 1'b0;
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_index   = coab_pkg::REG_CURSOR_LEFT;
        cfg_wr_data    = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = coab_pkg::ACTION_LOAD;
        m_tready       = 1'b0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        win_left       = '0;
        win_top        = '0;
        win_width      = '0;
        win_height     = '0;
        win_layout     = coab_pkg::LAYOUT_PASS;
        foreach (bitmap_loaded[i])
            bitmap_loaded[i] = 1'b0;

        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_reset_state();
        test_blend_rules();
        test_layout_modes();
        test_window_edges();
        test_random_traffic(0, 0, 5);
        test_random_traffic(76, 0, 5);
        test_random_traffic(0, 76, 5);
        test_random_traffic(33, 33, 5);
        wait_idle();

        $display("Covered %0d cursor loads and %0d blend requests over %0d register writes;",
                 loads_sent, blends_sent, cfg_writes);
        $display("checked %0d blended pixels, %0d of them under the cursor, %0d errors.",
                 results_checked, hits_seen, error_count);
        if (error_count == 0) begin
            $display("tb_cursor_overlay_alpha_blend_unit: clean");
        end else begin
            $display("tb_cursor_overlay_alpha_blend_unit: errors");
        end
        $finish;
    end

endmodule

[files.f]
hdl/coab_pkg.sv
hdl/coab_hit.sv
hdl/coab_store.sv
hdl/coab_mix.sv
hdl/cursor_overlay_alpha_blend_unit.sv
verif/tb_cursor_overlay_alpha_blend_unit.sv
